@@ design/stir2_pkg.sv @@
// Shared constants and types for the Stirling number (second kind) block.
`default_nettype none

package stir2_pkg;

   localparam int MAX_N_DEFAULT       = 63;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int ARG_WIDTH           = 6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

endpackage

`default_nettype wire

@@ design/stir2_cell.sv @@
// One diagonal cell of the Stirling row: holds S(i, i-span+POS) and its overflow mark.
`default_nettype none

module stir2_cell #(
   parameter int VALUE_WIDTH = stir2_pkg::VALUE_WIDTH_DEFAULT,
   parameter int IDX_W       = 6,
   parameter int POS         = 0
) (
   input  wire logic                   clock,
   input  wire logic                   step,
   input  wire logic [IDX_W-1:0]       row,
   input  wire logic [IDX_W-1:0]       span,
   input  wire logic [VALUE_WIDTH-1:0] nb_value,
   input  wire logic                   nb_ovf,
   output logic [VALUE_WIDTH-1:0]      value,
   output logic                        ovf
);

   localparam int PROD_W = VALUE_WIDTH + IDX_W;

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic                   ovf_ff, ovf_in;
   logic [IDX_W:0]         col_sum;
   logic [IDX_W-1:0]       col;
   logic [IDX_W-1:0]       pos_idx;
   logic                   col_zero;
   logic [PROD_W-1:0]      prod;
   logic [VALUE_WIDTH:0]   sum;
   logic                   bad;

   always_comb begin
      pos_idx  = IDX_W'(POS);
      col_sum  = {1'b0, row} + (IDX_W + 1)'(POS);
      col_zero = (col_sum <= {1'b0, span});
      col      = IDX_W'(col_sum - {1'b0, span});
      prod     = PROD_W'(nb_value) * PROD_W'(col);
      sum      = {1'b0, value_ff} + {1'b0, prod[VALUE_WIDTH-1:0]};
      bad      = ovf_ff | nb_ovf | (|prod[PROD_W-1:VALUE_WIDTH]) | sum[VALUE_WIDTH];
      if (pos_idx > span) begin
         value_in = '0;
         ovf_in   = 1'b0;
      end else if (pos_idx == span) begin
         value_in = VALUE_WIDTH'(1);
         ovf_in   = 1'b0;
      end else if (col_zero) begin
         value_in = '0;
         ovf_in   = 1'b0;
      end else begin
         value_in = bad ? '0 : sum[VALUE_WIDTH-1:0];
         ovf_in   = bad;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         value_ff <= value_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign value = value_ff;
   assign ovf   = ovf_ff;

endmodule

`default_nettype wire

@@ design/stirling_second_kind.sv @@
// Top level: Stirling numbers of the second kind over a chain of diagonal cells.
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_n_value, req_k_value
//   rsp      out        rsp_valid, rsp_ready, rsp_stirling_result, rsp_overflow
//
// A general item (0 < k < n) steps through the cell chain row by row, one row of the
// recurrence per cycle, then waits in the hold state until the output register is free
// and moves the answer into it. Zero, equal, out-of-order and oversized arguments skip
// the chain and go straight to the hold state. One item is in work at a time.
// Reset clears the state machine and the output valid; cells are rebuilt by each item.
// A stalled response holds the finished answer in the cells until the output register is free.
`default_nettype none

module stirling_second_kind #(
   parameter int MAX_N       = stir2_pkg::MAX_N_DEFAULT,
   parameter int VALUE_WIDTH = stir2_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [stir2_pkg::ARG_WIDTH-1:0]      req_n_value,
   input  wire logic [stir2_pkg::ARG_WIDTH-1:0]      req_k_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [VALUE_WIDTH-1:0]                    rsp_stirling_result,
   output logic                                      rsp_overflow
);

   localparam int IDX_W = $clog2(MAX_N + 1);

   stir2_pkg::state_type state_ff, state_in;

   logic [IDX_W-1:0]       row_ff, row_in;
   logic [IDX_W-1:0]       n_ff, n_in;
   logic [IDX_W-1:0]       span_ff, span_in;
   logic                   spec_ff, spec_in;
   logic                   spec_one_ff, spec_one_in;
   logic                   spec_ovf_ff, spec_ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] result_ff, result_in;
   logic                   ovf_ff, ovf_in;
   logic                   step;
   logic                   accept;
   logic                   rsp_free;
   logic                   arg_big;

   logic [VALUE_WIDTH-1:0] cell_value [MAX_N+1];
   logic                   cell_ovf   [MAX_N+1];

   assign cell_value[MAX_N] = '0;
   assign cell_ovf[MAX_N]   = 1'b0;

   for (genvar e = 0; e < MAX_N; e++) begin : g_cell
      stir2_cell #(
         .VALUE_WIDTH (VALUE_WIDTH),
         .IDX_W       (IDX_W),
         .POS         (e)
      ) u_cell (
         .clock    (clock),
         .step     (step),
         .row      (row_ff),
         .span     (span_ff),
         .nb_value (cell_value[e+1]),
         .nb_ovf   (cell_ovf[e+1]),
         .value    (cell_value[e]),
         .ovf      (cell_ovf[e])
      );
   end

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign arg_big  = (32'(req_n_value) > 32'(MAX_N)) || (32'(req_k_value) > 32'(MAX_N));

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      n_in         = n_ff;
      span_in      = span_ff;
      spec_in      = spec_ff;
      spec_one_in  = spec_one_ff;
      spec_ovf_in  = spec_ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      result_in    = result_ff;
      ovf_in       = ovf_ff;
      step         = 1'b0;
      accept       = 1'b0;
      req_ready    = 1'b0;
      case (state_ff)
         stir2_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept) begin
               row_in      = IDX_W'(1);
               n_in        = IDX_W'(req_n_value);
               span_in     = IDX_W'(req_n_value - req_k_value);
               spec_ovf_in = arg_big;
               spec_one_in = (req_k_value == req_n_value) && (req_n_value != '0);
               spec_in     = arg_big || (req_n_value == '0) || (req_k_value == '0) ||
                             (req_k_value >= req_n_value);
               state_in    = spec_in ? stir2_pkg::ST_HOLD : stir2_pkg::ST_RUN;
            end
         end
         stir2_pkg::ST_RUN: begin
            step = 1'b1;
            if (row_ff == n_ff) begin
               state_in = stir2_pkg::ST_HOLD;
            end else begin
               row_in = row_ff + IDX_W'(1);
            end
         end
         stir2_pkg::ST_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               if (spec_ff) begin
                  result_in = (spec_one_ff && !spec_ovf_ff) ? VALUE_WIDTH'(1) : '0;
                  ovf_in    = spec_ovf_ff;
               end else begin
                  result_in = cell_ovf[0] ? '0 : cell_value[0];
                  ovf_in    = cell_ovf[0];
               end
               state_in = stir2_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = stir2_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stir2_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      span_ff     <= span_in;
      spec_ff     <= spec_in;
      spec_one_ff <= spec_one_in;
      spec_ovf_ff <= spec_ovf_in;
      result_ff   <= result_in;
      ovf_ff      <= ovf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_stirling_result = result_ff;
   assign rsp_overflow        = ovf_ff;

endmodule

`default_nettype wire
